// ===== hdl/lbsc_pkg.sv =====
package lbsc_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int KEY_W       = 25;
  localparam int SUB_W       = 13;
  localparam int PKEY_W      = 12;
  localparam int CAP_W       = 7;
  localparam logic [CAP_W-1:0] CAP_RST = 7'd64;

  // Configuration register indexes.
  localparam logic CFG_TOTAL    = 1'b0;
  localparam logic CFG_PER_PAGE = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [31:0]      seen;
    logic [31:0]      att;
    logic [31:0]      first;
    logic [31:0]      last;
    logic [31:0]      stamp;
  } entry_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_PRD,
    ST_PCAP,
    ST_SCAN,
    ST_DEC,
    ST_EVICT,
    ST_PEVRD,
    ST_PEVWR,
    ST_WRITE
  } state_t;

  typedef enum logic [1:0] {
    SM_MATCH,
    SM_PAGE,
    SM_ALL
  } scan_mode_t;

endpackage

// ===== hdl/lru_bounded_subpage_catalogue_core.sv =====
// A header that hits an existing subpage passes from accept through a page memory read,
// its capture, one scan of the entry memory and the write that issues the result.
// A new subpage adds a decision step; each eviction adds another scan, the invalidation of
// the victim, an update of its page count when it lies on another page, and a new decision.
// Only one word is in flight; a result held by out_stall keeps the next word from finishing.
// After reset a clearing pass sweeps both memories and no word is taken.
module lru_bounded_subpage_catalogue_core #(
  parameter int ENTRIES = lbsc_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_magazine,
  input  logic [7:0]  in_page_number,
  input  logic [12:0] in_subcode,
  input  logic        in_subtitle,
  input  logic        in_identity_attested,
  input  logic [31:0] in_header_field_index,
  input  logic [31:0] in_frame_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_new,
  output logic [31:0] out_times_seen,
  output logic [31:0] out_times_attested,
  output logic [31:0] out_first_frame,
  output logic        out_page_subtitle,
  output logic [6:0]  out_evicted_count,
  output logic        out_truncated,
  output logic [6:0]  out_entries_in_use
);

  localparam int IW  = $clog2(ENTRIES);
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int WW  = (CW > lbsc_pkg::CAP_W ? CW : lbsc_pkg::CAP_W) + 1;
  localparam int PDW = CW + 1;
  localparam int KW  = lbsc_pkg::KEY_W;
  localparam int SW  = lbsc_pkg::SUB_W;

  lbsc_pkg::state_t     state_r, state_nxt;
  lbsc_pkg::scan_mode_t mode_r;

  logic [lbsc_pkg::CAP_W-1:0] tcap_r, pcap_r;
  logic [lbsc_pkg::PKEY_W-1:0] clr_r;

  logic [KW-1:0] key_r;
  logic          subt_r, att_r;
  logic [31:0]   hfi_r, frame_r;

  logic [CW-1:0] pcnt_r, used_r, evc_r;
  logic          pflag_r, trunc_r;
  logic [31:0]   touch_r;

  logic [CW-1:0] cnt_r;
  logic          rd_vld_r;
  logic [IW-1:0] rd_idx_r;

  logic          hit_r;
  logic [IW-1:0] hidx_r;
  logic [31:0]   hseen_r, hatt_r, hfirst_r, hlast_r;
  logic          free_ok_r;
  logic [IW-1:0] free_r;
  logic          best_ok_r;
  logic [IW-1:0] best_idx_r;
  logic [31:0]   best_age_r;
  logic [KW-1:0] best_key_r;

  logic          out_valid_r, out_is_new_r, out_psub_r, out_trunc_r;
  logic [31:0]   out_seen_r, out_att_r, out_first_r;
  logic [6:0]    out_evc_r, out_used_r;

  // Memory ports.
  logic                        em_rd_en, em_wr_en;
  logic [IW-1:0]               em_raddr, em_waddr;
  lbsc_pkg::entry_t            em_rdata, em_wdata;
  logic                        pm_rd_en, pm_wr_en;
  logic [lbsc_pkg::PKEY_W-1:0] pm_raddr, pm_waddr;
  logic [PDW-1:0]              pm_rdata, pm_wdata;

  lbsc_entry_mem #(.ENTRIES(ENTRIES)) u_entry_mem (
    .clk   (clk),
    .rd_en (em_rd_en),
    .raddr (em_raddr),
    .rdata (em_rdata),
    .wr_en (em_wr_en),
    .waddr (em_waddr),
    .wdata (em_wdata)
  );

  lbsc_page_mem #(.DW(PDW)) u_page_mem (
    .clk   (clk),
    .rd_en (pm_rd_en),
    .raddr (pm_raddr),
    .rdata (pm_rdata),
    .wr_en (pm_wr_en),
    .waddr (pm_waddr),
    .wdata (pm_wdata)
  );

  logic in_acc, out_acc, scan_done, wr_go, victim_cur;
  logic [lbsc_pkg::PKEY_W-1:0] cur_pkey, victim_pkey;
  logic [WW-1:0] tc_ext, pc_ext, tcap_eff, pcap_eff, used_ext, pcnt_ext, evc_ext, used_fin;
  logic need_page, need_all;
  logic [31:0] age, seen_n, att_n, base_seen, base_att;
  logic inc, better, cand;
  lbsc_pkg::entry_t new_word;

  assign in_stall = (state_r != lbsc_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign wr_go    = (state_r == lbsc_pkg::ST_WRITE) && !(out_valid_r && out_stall);

  assign cur_pkey    = key_r[KW-1:SW];
  assign victim_pkey = best_key_r[KW-1:SW];
  assign victim_cur  = (victim_pkey == cur_pkey);

  // A capacity of zero acts as one, anything above the table size as the table size.
  assign tc_ext   = WW'(tcap_r);
  assign pc_ext   = WW'(pcap_r);
  assign tcap_eff = (tcap_r == '0) ? WW'(1) : ((tc_ext > WW'(ENTRIES)) ? WW'(ENTRIES) : tc_ext);
  assign pcap_eff = (pcap_r == '0) ? WW'(1) : ((pc_ext > WW'(ENTRIES)) ? WW'(ENTRIES) : pc_ext);
  assign used_ext = WW'(used_r);
  assign pcnt_ext = WW'(pcnt_r);
  assign evc_ext  = WW'(evc_r);
  assign need_page = (pcnt_ext >= pcap_eff) && (pcnt_r != '0);
  assign need_all  = (used_ext >= tcap_eff) && (used_r != '0);

  assign scan_done = (state_r == lbsc_pkg::ST_SCAN) && (cnt_r == CW'(ENTRIES)) && !rd_vld_r;

  // Recency compare on the word read back from the entry memory.
  assign age  = touch_r - em_rdata.stamp;
  assign cand = em_rdata.valid &&
                ((mode_r == lbsc_pkg::SM_ALL) || (em_rdata.key[KW-1:SW] == cur_pkey));
  assign better = !best_ok_r || (age > best_age_r) ||
                  ((age == best_age_r) && (em_rdata.key < best_key_r));

  // A new entry always counts; an existing one counts when the field index changed.
  assign base_seen = hit_r ? hseen_r : 32'd0;
  assign base_att  = hit_r ? hatt_r : 32'd0;
  assign inc       = !hit_r || (hfi_r != hlast_r);
  assign seen_n    = (inc && (base_seen != 32'hFFFF_FFFF)) ? base_seen + 32'd1 : base_seen;
  assign att_n     = (inc && att_r && (base_att != 32'hFFFF_FFFF)) ? base_att + 32'd1 : base_att;
  assign used_fin  = used_ext + WW'(!hit_r);

  always_comb begin
    new_word.valid = 1'b1;
    new_word.key   = key_r;
    new_word.seen  = seen_n;
    new_word.att   = att_n;
    new_word.first = hit_r ? hfirst_r : frame_r;
    new_word.last  = hfi_r;
    new_word.stamp = touch_r + 32'd1;
  end

  always_comb begin
    em_rd_en = (state_r == lbsc_pkg::ST_SCAN) && (cnt_r != CW'(ENTRIES));
    em_raddr = cnt_r[IW-1:0];
    em_wr_en = 1'b0;
    em_waddr = best_idx_r;
    em_wdata = new_word;
    pm_rd_en = 1'b0;
    pm_raddr = cur_pkey;
    pm_wr_en = 1'b0;
    pm_waddr = cur_pkey;
    pm_wdata = {pflag_r, CW'(pcnt_r + CW'(!hit_r))};
    state_nxt = state_r;
    case (state_r)
      lbsc_pkg::ST_CLR: begin
        em_wr_en       = ({1'b0, clr_r} < (lbsc_pkg::PKEY_W + 1)'(ENTRIES));
        em_waddr       = clr_r[IW-1:0];
        em_wdata.valid = 1'b0;
        pm_wr_en       = 1'b1;
        pm_waddr       = clr_r;
        pm_wdata       = '0;
        if (clr_r == '1) begin
          state_nxt = lbsc_pkg::ST_IDLE;
        end
      end
      lbsc_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = lbsc_pkg::ST_PRD;
        end
      end
      lbsc_pkg::ST_PRD: begin
        pm_rd_en  = 1'b1;
        state_nxt = lbsc_pkg::ST_PCAP;
      end
      lbsc_pkg::ST_PCAP: begin
        state_nxt = lbsc_pkg::ST_SCAN;
      end
      lbsc_pkg::ST_SCAN: begin
        if (scan_done) begin
          if (mode_r != lbsc_pkg::SM_MATCH) begin
            state_nxt = lbsc_pkg::ST_EVICT;
          end else if (hit_r) begin
            state_nxt = lbsc_pkg::ST_WRITE;
          end else begin
            state_nxt = lbsc_pkg::ST_DEC;
          end
        end
      end
      lbsc_pkg::ST_DEC: begin
        if (need_page || need_all) begin
          state_nxt = lbsc_pkg::ST_SCAN;
        end else begin
          state_nxt = lbsc_pkg::ST_WRITE;
        end
      end
      lbsc_pkg::ST_EVICT: begin
        em_wr_en       = 1'b1;
        em_waddr       = best_idx_r;
        em_wdata.valid = 1'b0;
        state_nxt = victim_cur ? lbsc_pkg::ST_DEC : lbsc_pkg::ST_PEVRD;
      end
      lbsc_pkg::ST_PEVRD: begin
        pm_rd_en  = 1'b1;
        pm_raddr  = victim_pkey;
        state_nxt = lbsc_pkg::ST_PEVWR;
      end
      lbsc_pkg::ST_PEVWR: begin
        // A count that reaches zero marks the page as gone.
        pm_wr_en  = 1'b1;
        pm_waddr  = victim_pkey;
        pm_wdata  = {pm_rdata[CW], CW'(pm_rdata[CW-1:0] - CW'(1))};
        state_nxt = lbsc_pkg::ST_DEC;
      end
      lbsc_pkg::ST_WRITE: begin
        if (wr_go) begin
          em_wr_en  = 1'b1;
          em_waddr  = hit_r ? hidx_r : free_r;
          pm_wr_en  = 1'b1;
          state_nxt = lbsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lbsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lbsc_pkg::ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      tcap_r      <= lbsc_pkg::CAP_RST;
      pcap_r      <= lbsc_pkg::CAP_RST;
      used_r      <= '0;
      trunc_r     <= 1'b0;
      touch_r     <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      cnt_r       <= '0;
      mode_r      <= lbsc_pkg::SM_MATCH;
      hit_r       <= 1'b0;
      free_ok_r   <= 1'b0;
      best_ok_r   <= 1'b0;
      evc_r       <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lbsc_pkg::CFG_TOTAL) begin
          tcap_r <= cfg_data;
        end else if (cfg_index == lbsc_pkg::CFG_PER_PAGE) begin
          pcap_r <= cfg_data;
        end
      end
      if (state_r == lbsc_pkg::ST_CLR) begin
        clr_r <= clr_r + (lbsc_pkg::PKEY_W)'(1);
      end
      if (out_acc && !wr_go) begin
        out_valid_r <= 1'b0;
      end

      rd_vld_r <= em_rd_en;
      if (em_rd_en) begin
        cnt_r <= cnt_r + CW'(1);
      end

      if (in_acc) begin
        hit_r     <= 1'b0;
        free_ok_r <= 1'b0;
        evc_r     <= '0;
      end

      if (state_r == lbsc_pkg::ST_PCAP) begin
        cnt_r     <= '0;
        mode_r    <= lbsc_pkg::SM_MATCH;
      end
      if (state_r == lbsc_pkg::ST_DEC) begin
        cnt_r     <= '0;
        best_ok_r <= 1'b0;
        mode_r    <= need_page ? lbsc_pkg::SM_PAGE : lbsc_pkg::SM_ALL;
      end

      if ((state_r == lbsc_pkg::ST_SCAN) && rd_vld_r) begin
        if (mode_r == lbsc_pkg::SM_MATCH) begin
          if (em_rdata.valid && (em_rdata.key == key_r)) begin
            hit_r <= 1'b1;
          end
          if (!em_rdata.valid && !free_ok_r) begin
            free_ok_r <= 1'b1;
          end
        end else if (cand && better) begin
          best_ok_r <= 1'b1;
        end
      end

      if (state_r == lbsc_pkg::ST_EVICT) begin
        used_r    <= used_r - CW'(1);
        evc_r     <= evc_r + CW'(1);
        trunc_r   <= 1'b1;
        free_ok_r <= 1'b1;
      end

      if (wr_go) begin
        used_r      <= used_r + CW'(!hit_r);
        touch_r     <= touch_r + 32'd1;
        out_valid_r <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r   <= {in_magazine, in_page_number, in_subcode};
      subt_r  <= in_subtitle;
      att_r   <= in_identity_attested;
      hfi_r   <= in_header_field_index;
      frame_r <= in_frame_number;
    end
    if (state_r == lbsc_pkg::ST_PCAP) begin
      pcnt_r  <= pm_rdata[CW-1:0];
      pflag_r <= ((pm_rdata[CW-1:0] != '0) && pm_rdata[CW]) || subt_r;
    end
    if ((state_r == lbsc_pkg::ST_SCAN) && rd_vld_r) begin
      if (mode_r == lbsc_pkg::SM_MATCH) begin
        if (em_rdata.valid && (em_rdata.key == key_r)) begin
          hidx_r   <= rd_idx_r;
          hseen_r  <= em_rdata.seen;
          hatt_r   <= em_rdata.att;
          hfirst_r <= em_rdata.first;
          hlast_r  <= em_rdata.last;
        end
        if (!em_rdata.valid && !free_ok_r) begin
          free_r <= rd_idx_r;
        end
      end else if (cand && better) begin
        best_idx_r <= rd_idx_r;
        best_age_r <= age;
        best_key_r <= em_rdata.key;
      end
    end
    rd_idx_r <= cnt_r[IW-1:0];
    if (state_r == lbsc_pkg::ST_EVICT) begin
      free_r <= best_idx_r;
      if (victim_cur) begin
        pcnt_r <= pcnt_r - CW'(1);
      end
    end
    if (wr_go) begin
      out_is_new_r <= !hit_r;
      out_seen_r   <= seen_n;
      out_att_r    <= att_n;
      out_first_r  <= new_word.first;
      out_psub_r   <= pflag_r;
      out_evc_r    <= evc_ext[6:0];
      out_trunc_r  <= trunc_r;
      out_used_r   <= used_fin[6:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_is_new         = out_is_new_r;
  assign out_times_seen     = out_seen_r;
  assign out_times_attested = out_att_r;
  assign out_first_frame    = out_first_r;
  assign out_page_subtitle  = out_psub_r;
  assign out_evicted_count  = out_evc_r;
  assign out_truncated      = out_trunc_r;
  assign out_entries_in_use = out_used_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(ENTRIES))
    else $error("entry count above table size");

  a_evict_sets_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lbsc_pkg::ST_EVICT) |=> trunc_r)
    else $error("eviction did not set the truncated flag");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lbsc_pkg::ST_CLR) |-> in_stall)
    else $error("word accepted during clearing pass");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == lbsc_pkg::ST_WRITE) && hit_r) |-> (evc_r == '0))
    else $error("existing entry caused an eviction");

  a_new_adds_one: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_go && !hit_r) |=> (used_r == CW'($past(used_r) + CW'(1))))
    else $error("new entry did not raise the entry count");

endmodule

// ===== hdl/lbsc_entry_mem.sv =====
module lbsc_entry_mem #(
  parameter int ENTRIES = lbsc_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(ENTRIES)-1:0] raddr,
  output lbsc_pkg::entry_t           rdata,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] waddr,
  input  lbsc_pkg::entry_t           wdata
);

  lbsc_pkg::entry_t mem [ENTRIES];
  lbsc_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/lbsc_page_mem.sv =====
module lbsc_page_mem #(
  parameter int DW = 8
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [lbsc_pkg::PKEY_W-1:0] raddr,
  output logic [DW-1:0]               rdata,
  input  logic                        wr_en,
  input  logic [lbsc_pkg::PKEY_W-1:0] waddr,
  input  logic [DW-1:0]               wdata
);

  logic [DW-1:0] mem [2**lbsc_pkg::PKEY_W];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
